// ----- hdl/gap_pkg.sv -----
`default_nettype none
package gap_pkg;

  typedef struct packed {
    logic       command;
    logic [4:0] column_line;
    logic [6:0] row_line;
    logic [4:0] column_span;
    logic [4:0] row_extent;
  } in_t;

  typedef struct packed {
    logic [3:0] placed_column;
    logic [5:0] placed_row;
    logic [6:0] rows_in_use;
    logic       overlap_flag;
    logic       overflow_flag;
  } out_t;

  typedef enum logic [1:0] {
    MODE_EXPLICIT,
    MODE_COL_ONLY,
    MODE_ROW_ONLY,
    MODE_AUTO
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WIN,
    S_READ,
    S_WAIT,
    S_EVAL,
    S_MRD,
    S_MWR,
    S_FIN,
    S_OVF
  } state_t;

  typedef struct packed {
    logic latch;
    logic clear;
    logic win_start;
    logic rd;
    logic take_fit;
    logic next_row;
    logic set_overlap;
    logic mark_start;
    logic mark_rd;
    logic mark_wr;
    logic finish;
    logic finish_ovf;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  win_ok;
    logic  cnt_last;
    logic  fit;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/gap_ctrl.sv -----
`default_nettype none
module gap_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        command,
  output logic             busy,
  output gap_pkg::cmd_t    cmd,
  input  wire gap_pkg::sts_t sts
);
  import gap_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (command) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            state_nxt = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        if (sts.mode == MODE_EXPLICIT) begin
          if (sts.win_ok) begin
            cmd.mark_start = 1'b1;
            state_nxt      = S_MRD;
          end else begin
            state_nxt = S_OVF;
          end
        end else begin
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        if (sts.win_ok) begin
          cmd.win_start = 1'b1;
          state_nxt     = S_READ;
        end else begin
          state_nxt = S_OVF;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        if (sts.cnt_last) state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.fit) begin
          cmd.take_fit   = 1'b1;
          cmd.mark_start = 1'b1;
          state_nxt      = S_MRD;
        end else if (sts.mode == MODE_ROW_ONLY) begin
          cmd.set_overlap = 1'b1;
          cmd.mark_start  = 1'b1;
          state_nxt       = S_MRD;
        end else begin
          cmd.next_row = 1'b1;
          state_nxt    = S_WIN;
        end
      end
      S_MRD: begin
        cmd.mark_rd = 1'b1;
        state_nxt   = S_MWR;
      end
      S_MWR: begin
        cmd.mark_wr = 1'b1;
        state_nxt   = sts.cnt_last ? S_FIN : S_MRD;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_OVF: begin
        cmd.finish_ovf = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/gap_dpath.sv -----
`default_nettype none
module gap_dpath #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gap_pkg::in_t  in_data,
  input  wire logic          cfg_we,
  input  wire logic [4:0]    cfg_wdata,
  input  wire gap_pkg::cmd_t cmd,
  output gap_pkg::sts_t      sts,
  output logic               out_strobe,
  output gap_pkg::out_t      out_data
);
  import gap_pkg::*;

  localparam int CNW = $clog2(MAX_COLUMNS + 1);
  localparam int RLIM = (MAX_ROWS > 64) ? MAX_ROWS : 64;
  // room for an explicit row line of up to 127 plus the largest span
  localparam int RCW = $clog2(RLIM + 160);
  localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [4:0]             ccount_r;
  logic [CNW-1:0]         ncols;
  logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]    vld_r;
  logic [MAX_COLUMNS-1:0] rdata_r, rword, acc_r, acc_nxt, span_m, fit_m;
  logic                   rvld_r, rd_pend_r;
  mode_t                  mode_r;
  logic [CNW-1:0]         cspan_r, col_r, lo_r, cur_col_r, fcol;
  logic [4:0]             rspan_r, cnt_r;
  logic [RCW-1:0]         cur_row_r, cursor_row_r, ptr_r, row_count_r, row_end;
  logic                   ovl_r, fit;

  // decoded item at accept
  logic [7:0]     cc8, cs8;
  logic [CNW-1:0] cspan_c, col_c;
  logic [4:0]     rspan_c, cl1;
  mode_t          mode_c;

  always_comb begin
    cc8 = {3'b0, ccount_r};
    if (cc8 == 8'd0) cc8 = 8'd1;
    if (cc8 > 8'(MAX_COLUMNS)) cc8 = 8'(MAX_COLUMNS);
    ncols = CNW'(cc8);
    cs8 = {3'b0, in_data.column_span};
    if (cs8 == 8'd0) cs8 = 8'd1;
    if (cs8 > cc8) cs8 = cc8;
    cspan_c = CNW'(cs8);
    rspan_c = (in_data.row_extent == 5'd0) ? 5'd1 : in_data.row_extent;
    cl1     = in_data.column_line - 5'd1;
    if (({3'b0, cl1} + cs8) > cc8) col_c = CNW'(cc8 - cs8);
    else                           col_c = CNW'(cl1);
    if (in_data.column_line == 5'd0) col_c = '0;
    if (in_data.column_line != 5'd0)
      mode_c = (in_data.row_line != 7'd0) ? MODE_EXPLICIT : MODE_COL_ONLY;
    else
      mode_c = (in_data.row_line != 7'd0) ? MODE_ROW_ONLY : MODE_AUTO;
  end

  assign rword  = rvld_r ? rdata_r : '0;
  assign span_m = {MAX_COLUMNS{1'b1}} >> (CNW'(MAX_COLUMNS) - cspan_r);
  assign row_end = cur_row_r + RCW'(rspan_r);
  assign fit_m  = span_m << col_r;

  // first free start column in the window
  always_comb begin
    fit  = 1'b0;
    fcol = '0;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (!fit && (CNW'(c) >= lo_r)
          && (({1'b0, CNW'(c)} + {1'b0, cspan_r}) <= {1'b0, ncols})
          && ((acc_r & (span_m << c)) == '0)
          && (mode_r != MODE_COL_ONLY || CNW'(c) == lo_r)) begin
        fit  = 1'b1;
        fcol = CNW'(c);
      end
    end
  end

  always_comb begin
    sts.mode     = mode_r;
    sts.win_ok   = ({1'b0, row_end} <= (RCW + 1)'(MAX_ROWS));
    sts.cnt_last = (cnt_r == rspan_r - 5'd1);
    sts.fit      = fit;
  end

  assign acc_nxt = rd_pend_r ? (acc_r | rword) : acc_r;

  always_ff @(posedge clk) begin
    if (cmd.rd || cmd.mark_rd) begin
      rdata_r <= mem[ptr_r[AW-1:0]];
      rvld_r  <= vld_r[ptr_r[AW-1:0]];
    end
    if (cmd.mark_wr) mem[ptr_r[AW-1:0]] <= rword | fit_m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) vld_r <= '0;
    else if (cmd.mark_wr)    vld_r[ptr_r[AW-1:0]] <= 1'b1;
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r  <= mode_c;
      cspan_r <= cspan_c;
      rspan_r <= rspan_c;
      col_r   <= col_c;
      ovl_r   <= 1'b0;
      if (mode_c == MODE_AUTO) begin
        cur_row_r <= cursor_row_r;
        lo_r      <= cur_col_r;
      end else begin
        cur_row_r <= (mode_c == MODE_COL_ONLY) ? '0 : RCW'(in_data.row_line - 7'd1);
        lo_r      <= (mode_c == MODE_COL_ONLY) ? col_c : '0;
      end
    end
    if (cmd.win_start) begin
      acc_r <= '0;
      ptr_r <= cur_row_r;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (cmd.mark_start) begin
        ptr_r <= cur_row_r;
        cnt_r <= '0;
      end else if (cmd.rd || cmd.mark_wr) begin
        ptr_r <= ptr_r + RCW'(1);
        cnt_r <= cnt_r + 5'd1;
      end
    end
    if (cmd.next_row) begin
      cur_row_r <= cur_row_r + RCW'(1);
      if (mode_r == MODE_AUTO) lo_r <= '0;
    end
    if (cmd.take_fit) col_r <= fcol;
    if (cmd.set_overlap) begin
      col_r <= '0;
      ovl_r <= 1'b1;
    end
  end

  // persistent state and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccount_r     <= 5'd1;
      cursor_row_r <= '0;
      cur_col_r    <= '0;
      row_count_r  <= '0;
      rd_pend_r    <= 1'b0;
      out_strobe   <= 1'b0;
    end else begin
      rd_pend_r  <= cmd.rd;
      out_strobe <= cmd.clear || cmd.finish || cmd.finish_ovf;
      if (cfg_we) ccount_r <= cfg_wdata;
      if (cmd.clear) begin
        cursor_row_r <= '0;
        cur_col_r    <= '0;
        row_count_r  <= '0;
        out_data     <= '0;
      end
      if (cmd.finish_ovf) begin
        out_data <= {4'd0, 6'd0, 7'(row_count_r), 1'b0, 1'b1};
      end
      if (cmd.finish) begin
        if (row_end > row_count_r) row_count_r <= row_end;
        out_data.placed_column <= 4'(col_r);
        out_data.placed_row    <= 6'(cur_row_r);
        out_data.rows_in_use   <= 7'((row_end > row_count_r) ? row_end : row_count_r);
        out_data.overlap_flag  <= ovl_r;
        out_data.overflow_flag <= 1'b0;
        if (mode_r == MODE_AUTO) begin
          // wrap the cursor at the right edge
          if ((col_r + cspan_r) >= ncols) begin
            cur_col_r    <= '0;
            cursor_row_r <= cur_row_r + RCW'(1);
          end else begin
            cur_col_r    <= col_r + cspan_r;
            cursor_row_r <= cur_row_r;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/grid_auto_placement_core.sv -----
`default_nettype none
// Grid auto-placement engine with a row-by-column occupancy bitmap.
// Input: raise start with in_data for one cycle while busy is low; the
// transaction is taken at that edge. command 1 clears the bitmap, cursor and
// row count; command 0 places one item.
// Output: each transaction yields exactly one result, shown on out_data for a
// single cycle with out_strobe high. The receiver cannot stall.
// Configuration: cfg_we with cfg_wdata writes column_count; the user
// must write it only while idle, as the block does not enforce this.
// Latency: a clear reports the cycle after acceptance and busy stays low.
// A placement checks one candidate row window per pass: row_extent memory
// reads, a settle state and an evaluate state, all start columns of that
// window tested at once. Marking reads and then writes each spanned row.
// Explicit items go straight to marking. A searching item's time depends
// on the bitmap contents and is set by the single memory read port.
// Reset: the bitmap reads as empty at once (per-row valid bits), cursor
// and row count are zero, column_count is 1.
module grid_auto_placement_core #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire gap_pkg::in_t in_data,
  output logic              out_strobe,
  output gap_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic [4:0]   cfg_wdata
);
  import gap_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gap_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_data.command),
    .busy    (busy),
    .cmd     (cmd),
    .sts     (sts)
  );

  gap_dpath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
